// ===== rtl/core/sckd_pkg.sv =====
// ----------------------------------------------------------------------------
// sckd_pkg: shared types and constants of the scan code to key decoder
// Holds the decoder state and result types, scan code constants, special key
// codes and the printing-key character table.
// ----------------------------------------------------------------------------
`default_nettype none

package sckd_pkg;

	// Scan codes with a fixed meaning
	localparam logic [7:0] SC_ESC        = 8'h01;
	localparam logic [7:0] SC_BKSP       = 8'h0e;
	localparam logic [7:0] SC_TAB        = 8'h0f;
	localparam logic [7:0] SC_ENTER      = 8'h1c;
	localparam logic [7:0] SC_CTRL_MAKE  = 8'h1d;
	localparam logic [7:0] SC_CTRL_BRK   = 8'h9d;
	localparam logic [7:0] SC_LSHIFT_MK  = 8'h2a;
	localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'haa;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hb6;
	localparam logic [7:0] SC_ALT_MAKE   = 8'h38;
	localparam logic [7:0] SC_ALT_BRK    = 8'hb8;
	localparam logic [7:0] SC_SPACE      = 8'h39;
	localparam logic [7:0] SC_CAPS       = 8'h3a;
	localparam logic [7:0] SC_PREFIX     = 8'he0;

	// Extended (prefixed) navigation codes
	localparam logic [7:0] SC_X_PGUP  = 8'h49;
	localparam logic [7:0] SC_X_PGDN  = 8'h51;
	localparam logic [7:0] SC_X_UP    = 8'h48;
	localparam logic [7:0] SC_X_HOME  = 8'h47;
	localparam logic [7:0] SC_X_END   = 8'h4f;
	localparam logic [7:0] SC_X_INS   = 8'h52;
	localparam logic [7:0] SC_X_DEL   = 8'h53;
	localparam logic [7:0] SC_X_LEFT  = 8'h4b;
	localparam logic [7:0] SC_X_DOWN  = 8'h50;
	localparam logic [7:0] SC_X_RIGHT = 8'h4d;

	// Lead byte thresholds for multi-byte gathers
	localparam logic [7:0] LEAD_SHORT = 8'hc0;
	localparam logic [7:0] LEAD_MID   = 8'he0;
	localparam logic [7:0] LEAD_LONG  = 8'hf0;

	// Special key codes
	localparam logic [4:0] SK_NONE     = 5'd0;
	localparam logic [4:0] SK_ESC      = 5'd1;
	localparam logic [4:0] SK_BKSP     = 5'd2;
	localparam logic [4:0] SK_TAB      = 5'd3;
	localparam logic [4:0] SK_ENTER    = 5'd4;
	localparam logic [4:0] SK_CAPS     = 5'd5;
	localparam logic [4:0] SK_SPACE    = 5'd6;
	localparam logic [4:0] SK_SHIFTDN  = 5'd7;
	localparam logic [4:0] SK_SHIFTUP  = 5'd8;
	localparam logic [4:0] SK_PGUP     = 5'd9;
	localparam logic [4:0] SK_PGDN     = 5'd10;
	localparam logic [4:0] SK_UP       = 5'd11;
	localparam logic [4:0] SK_HOME     = 5'd12;
	localparam logic [4:0] SK_END      = 5'd13;
	localparam logic [4:0] SK_INS      = 5'd14;
	localparam logic [4:0] SK_DEL      = 5'd15;
	localparam logic [4:0] SK_LEFT     = 5'd16;
	localparam logic [4:0] SK_DOWN     = 5'd17;
	localparam logic [4:0] SK_RIGHT    = 5'd18;

	// Control part of the decoder state (reset clears it)
	typedef struct packed {
		logic       shift_held;
		logic       ctrl_held;
		logic       alt_held;
		logic       prefix_pending;
		logic [1:0] bytes_still_needed;
		logic [1:0] gather_index;
	} ctl_state_t;

	// Gathered bytes of a multi-byte run
	typedef logic [3:0][7:0] gather_buf_t;

	// One result item
	typedef struct packed {
		logic [4:0] special_key;
		logic [2:0] byte_count;
		logic [7:0] char_first;
		logic [7:0] char_second;
		logic [7:0] char_third;
		logic [7:0] char_fourth;
		logic       shift_now;
		logic       ctrl_now;
		logic       alt_now;
	} result_t;

	// Character pair {shifted, plain} of a printing make code, zero if none
	function automatic logic [15:0] ascii_pair(input logic [7:0] code);
		logic [15:0] pair;
		pair = 16'h0000;
		unique case (code)
			8'h02: pair = {8'h21, 8'h31};
			8'h03: pair = {8'h40, 8'h32};
			8'h04: pair = {8'h23, 8'h33};
			8'h05: pair = {8'h24, 8'h34};
			8'h06: pair = {8'h25, 8'h35};
			8'h07: pair = {8'h5e, 8'h36};
			8'h08: pair = {8'h26, 8'h37};
			8'h09: pair = {8'h2a, 8'h38};
			8'h0a: pair = {8'h28, 8'h39};
			8'h0b: pair = {8'h29, 8'h30};
			8'h0c: pair = {8'h5f, 8'h2d};
			8'h0d: pair = {8'h2b, 8'h3d};
			8'h10: pair = {8'h51, 8'h71};
			8'h11: pair = {8'h57, 8'h77};
			8'h12: pair = {8'h45, 8'h65};
			8'h13: pair = {8'h52, 8'h72};
			8'h14: pair = {8'h54, 8'h74};
			8'h15: pair = {8'h59, 8'h79};
			8'h16: pair = {8'h55, 8'h75};
			8'h17: pair = {8'h49, 8'h69};
			8'h18: pair = {8'h4f, 8'h6f};
			8'h19: pair = {8'h50, 8'h70};
			8'h1a: pair = {8'h7b, 8'h5b};
			8'h1b: pair = {8'h7d, 8'h5d};
			8'h1e: pair = {8'h41, 8'h61};
			8'h1f: pair = {8'h53, 8'h73};
			8'h20: pair = {8'h44, 8'h64};
			8'h21: pair = {8'h46, 8'h66};
			8'h22: pair = {8'h47, 8'h67};
			8'h23: pair = {8'h48, 8'h68};
			8'h24: pair = {8'h4a, 8'h6a};
			8'h25: pair = {8'h4b, 8'h6b};
			8'h26: pair = {8'h4c, 8'h6c};
			8'h27: pair = {8'h3a, 8'h3b};
			8'h28: pair = {8'h22, 8'h27};
			8'h29: pair = {8'h7e, 8'h60};
			8'h2b: pair = {8'h7c, 8'h5c};
			8'h2c: pair = {8'h5a, 8'h7a};
			8'h2d: pair = {8'h58, 8'h78};
			8'h2e: pair = {8'h43, 8'h63};
			8'h2f: pair = {8'h56, 8'h76};
			8'h30: pair = {8'h42, 8'h62};
			8'h31: pair = {8'h4e, 8'h6e};
			8'h32: pair = {8'h4d, 8'h6d};
			8'h33: pair = {8'h3c, 8'h2c};
			8'h34: pair = {8'h3e, 8'h2e};
			8'h35: pair = {8'h3f, 8'h2f};
			8'h56: pair = {8'h3e, 8'h3c};
			default: pair = 16'h0000;
		endcase
		return pair;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sckd_step.sv =====
// ----------------------------------------------------------------------------
// sckd_step: one-byte decode step
// Combinational next state and result for one scan byte, given the current
// modifier, prefix and gather state.
// ----------------------------------------------------------------------------
`default_nettype none

module sckd_step (
	input  wire logic [7:0]           scan_byte,
	input  wire sckd_pkg::ctl_state_t ctl,
	input  wire sckd_pkg::gather_buf_t gbuf,
	output sckd_pkg::ctl_state_t      ctl_nxt,
	output sckd_pkg::gather_buf_t     gbuf_nxt,
	output logic                      has_result,
	output sckd_pkg::result_t         result
);

	logic [15:0] pair;
	logic [7:0]  ascii;
	logic [1:0]  need_left;
	logic [3:0][7:0] chars;
	logic [2:0]  count;
	logic [4:0]  skey;

	assign pair      = sckd_pkg::ascii_pair(scan_byte);
	assign ascii     = ctl.shift_held ? pair[15:8] : pair[7:0];
	assign need_left = ctl.bytes_still_needed - 2'd1;

	// Decode the byte and update the state
	always_comb begin
		ctl_nxt    = ctl;
		gbuf_nxt   = gbuf;
		has_result = 1'b0;
		chars      = '0;
		count      = 3'd0;
		skey       = sckd_pkg::SK_NONE;

		if (ctl.bytes_still_needed != 2'd0) begin
			// Gather in progress: take the byte raw
			gbuf_nxt[ctl.gather_index] = scan_byte;
			ctl_nxt.bytes_still_needed = need_left;
			if (need_left != 2'd0) begin
				ctl_nxt.gather_index = ctl.gather_index + 2'd1;
			end else begin
				has_result = 1'b1;
				count      = {1'b0, ctl.gather_index} + 3'd1;
				for (int k = 0; k < 4; k++) begin
					if (k[1:0] == ctl.gather_index) begin
						chars[k] = scan_byte;
					end else if (k[1:0] < ctl.gather_index) begin
						chars[k] = gbuf[k];
					end
				end
				ctl_nxt.gather_index = 2'd0;
			end
		end else if (ctl.prefix_pending) begin
			// Extended code: navigation keys and right ctrl/alt
			ctl_nxt.prefix_pending = 1'b0;
			has_result = 1'b1;
			unique case (scan_byte)
				sckd_pkg::SC_X_PGUP:    skey = sckd_pkg::SK_PGUP;
				sckd_pkg::SC_X_PGDN:    skey = sckd_pkg::SK_PGDN;
				sckd_pkg::SC_X_UP:      skey = sckd_pkg::SK_UP;
				sckd_pkg::SC_X_HOME:    skey = sckd_pkg::SK_HOME;
				sckd_pkg::SC_X_END:     skey = sckd_pkg::SK_END;
				sckd_pkg::SC_X_INS:     skey = sckd_pkg::SK_INS;
				sckd_pkg::SC_X_DEL:     skey = sckd_pkg::SK_DEL;
				sckd_pkg::SC_X_LEFT:    skey = sckd_pkg::SK_LEFT;
				sckd_pkg::SC_X_DOWN:    skey = sckd_pkg::SK_DOWN;
				sckd_pkg::SC_X_RIGHT:   skey = sckd_pkg::SK_RIGHT;
				sckd_pkg::SC_CTRL_MAKE: ctl_nxt.ctrl_held = 1'b1;
				sckd_pkg::SC_CTRL_BRK:  ctl_nxt.ctrl_held = 1'b0;
				sckd_pkg::SC_ALT_MAKE:  ctl_nxt.alt_held = 1'b1;
				sckd_pkg::SC_ALT_BRK:   ctl_nxt.alt_held = 1'b0;
				default:                skey = sckd_pkg::SK_NONE;
			endcase
		end else begin
			// Plain byte
			has_result = 1'b1;
			unique case (scan_byte)
				sckd_pkg::SC_ESC:   skey = sckd_pkg::SK_ESC;
				sckd_pkg::SC_BKSP:  skey = sckd_pkg::SK_BKSP;
				sckd_pkg::SC_TAB:   skey = sckd_pkg::SK_TAB;
				sckd_pkg::SC_ENTER: skey = sckd_pkg::SK_ENTER;
				sckd_pkg::SC_CAPS:  skey = sckd_pkg::SK_CAPS;
				sckd_pkg::SC_SPACE: skey = sckd_pkg::SK_SPACE;
				sckd_pkg::SC_LSHIFT_MK, sckd_pkg::SC_RSHIFT_MK: begin
					ctl_nxt.shift_held = 1'b1;
					skey = sckd_pkg::SK_SHIFTDN;
				end
				sckd_pkg::SC_LSHIFT_BRK, sckd_pkg::SC_RSHIFT_BRK: begin
					ctl_nxt.shift_held = 1'b0;
					skey = sckd_pkg::SK_SHIFTUP;
				end
				sckd_pkg::SC_CTRL_MAKE: ctl_nxt.ctrl_held = 1'b1;
				sckd_pkg::SC_CTRL_BRK:  ctl_nxt.ctrl_held = 1'b0;
				sckd_pkg::SC_ALT_MAKE:  ctl_nxt.alt_held = 1'b1;
				sckd_pkg::SC_ALT_BRK:   ctl_nxt.alt_held = 1'b0;
				sckd_pkg::SC_PREFIX: begin
					ctl_nxt.prefix_pending = 1'b1;
					has_result = 1'b0;
				end
				default: begin
					priority if (ascii != 8'h00) begin
						chars[0] = ascii;
						count    = 3'd1;
					end else if (scan_byte >= sckd_pkg::LEAD_SHORT) begin
						// Lead byte: start a gather of 1 to 3 more bytes
						has_result  = 1'b0;
						gbuf_nxt[0] = scan_byte;
						ctl_nxt.gather_index = 2'd1;
						priority if (scan_byte >= sckd_pkg::LEAD_LONG) begin
							ctl_nxt.bytes_still_needed = 2'd3;
						end else if (scan_byte >= sckd_pkg::LEAD_MID) begin
							ctl_nxt.bytes_still_needed = 2'd2;
						end else begin
							ctl_nxt.bytes_still_needed = 2'd1;
						end
					end else begin
						chars[0] = scan_byte;
						count    = 3'd1;
					end
				end
			endcase
		end
	end

	// Assemble the result with the updated modifier flags
	always_comb begin
		result.special_key = skey;
		result.byte_count  = count;
		result.char_first  = chars[0];
		result.char_second = chars[1];
		result.char_third  = chars[2];
		result.char_fourth = chars[3];
		result.shift_now   = ctl_nxt.shift_held;
		result.ctrl_now    = ctl_nxt.ctrl_held;
		result.alt_now     = ctl_nxt.alt_held;
	end

endmodule

`default_nettype wire

// ===== rtl/core/scan_code_to_key_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// scan_code_to_key_decoder_unit: set-1 scan code to key event decoder
// Turns raw keyboard scan bytes into ASCII characters, special key codes and
// modifier flags, with extended-prefix and multi-byte gather handling.
// ----------------------------------------------------------------------------
// Usage:
//   Scan bytes enter on the s_ channel (s_tdata[7:0]), one per accepted item.
//   Key events leave on the m_ channel, one item per event. Bytes that only
//   set the extended prefix or feed a multi-byte gather give no item.
//   Path: each taken byte sits in the input register, then moves on into the
//   result register, where m_tvalid rises once a byte that gives a result lands.
//   Throughput: one byte per cycle unless a pending result stalls; the decode
//   is a single table lookup and flag update between the input and result registers.
//   Stall: while m_tready is low and a result waits, the input register holds
//   its byte and s_tready drops once that register is full; nothing is lost.
//   A byte that gives no result also waits until the pending result is taken.
//   Reset: modifiers, prefix and gather state clear; both channels go idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_code_to_key_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] scan_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // [4:0] special_key, [7:5] byte_count,
	                                    // [15:8] char_first, [23:16] char_second,
	                                    // [31:24] char_third, [39:32] char_fourth,
	                                    // [40] shift_now, [41] ctrl_now,
	                                    // [42] alt_now, [47:43] zero
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	sckd_pkg::ctl_state_t  ctl_q;
	sckd_pkg::ctl_state_t  ctl_nxt;
	sckd_pkg::gather_buf_t gbuf_q;
	sckd_pkg::gather_buf_t gbuf_nxt;
	logic                  has_result;
	sckd_pkg::result_t     result;
	logic                  out_valid_q;
	sckd_pkg::result_t     result_q;
	logic                  advance;

	// Move the held byte on when the result register can take it
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	sckd_step u_step (
		.scan_byte  (byte_s1),
		.ctl        (ctl_q),
		.gbuf       (gbuf_q),
		.ctl_nxt    (ctl_nxt),
		.gbuf_nxt   (gbuf_nxt),
		.has_result (has_result),
		.result     (result)
	);

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gbuf_q <= gbuf_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000,
	                   result_q.alt_now, result_q.ctrl_now, result_q.shift_now,
	                   result_q.char_fourth, result_q.char_third,
	                   result_q.char_second, result_q.char_first,
	                   result_q.byte_count, result_q.special_key};

endmodule

`default_nettype wire
